FILE: rtl/core/u8vd_pkg.sv
// Package with the error codes, result layout and printable rule of the UTF-8 validating decoder.
package u8vd_pkg;

	localparam int unsigned CpW  = 21;
	localparam int unsigned ErrW = 3;

	localparam logic [ErrW-1:0] ERR_NONE      = 3'd0;
	localparam logic [ErrW-1:0] ERR_BAD_LEAD  = 3'd1;
	localparam logic [ErrW-1:0] ERR_BAD_CONT  = 3'd2;
	localparam logic [ErrW-1:0] ERR_SURROGATE = 3'd3;
	localparam logic [ErrW-1:0] ERR_TRUNCATED = 3'd4;

	typedef struct packed {
		logic            string_valid;
		logic [ErrW-1:0] error_code;
		logic            printable;
		logic [CpW-1:0]  code_point;
	} result_t;

	function automatic logic is_printable(input logic [CpW-1:0] cp);
		logic p;
		p = 1'b1;
		if (cp <= 21'h1F || cp == 21'h7F) p = 1'b0;
		if (cp >= 21'h80 && cp <= 21'h9F) p = 1'b0;
		if (cp == 21'h2028 || cp == 21'h2029) p = 1'b0;
		if (cp == 21'h200E || cp == 21'h200F) p = 1'b0;
		if (cp >= 21'h202A && cp <= 21'h202E) p = 1'b0;
		if (cp >= 21'hFFF9 && cp <= 21'hFFFF) p = 1'b0;
		return p;
	endfunction

endpackage

FILE: rtl/core/utf8_validate_decode_unit.sv
// UTF-8 validating decoder that takes one byte per transaction and returns code points.
// An accepted byte is held in the input register, then its result in the result register behind m_tvalid.
// Throughput: one byte per cycle; a stalled output holds the input register, and s_tready drops.
// The input register and the result register form two stages; m_tready reaches s_tready directly.
// Reset (arst_n low) clears the decoder state and both valid flags at once.
// A string is closed by its last byte, after which all decoder state returns to reset.
module utf8_validate_decode_unit
	import u8vd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [20:0] code_point, [21] printable, [24:22] error_code,
	                               // [25] string_valid, [31:26] zero
	output logic        m_tlast    // end_of_string
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        fire_s1;

	logic [1:0]      pend_q;
	logic [CpW-1:0]  partial_q;
	logic            lead_ed_q;
	logic            first_cont_q;
	logic            err_latched_q;

	logic [1:0]      pend_d;
	logic [CpW-1:0]  partial_d;
	logic            lead_ed_d;
	logic            first_cont_d;
	logic            err_latched_d;

	logic [ErrW-1:0] err_c;
	logic [CpW-1:0]  cp_c;
	logic            done_c;
	logic            emit_c;
	result_t         res_c;

	logic            out_valid_q;
	result_t         out_q;
	logic            out_last_q;

	assign fire_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		pend_d        = pend_q;
		partial_d     = partial_q;
		lead_ed_d     = lead_ed_q;
		first_cont_d  = first_cont_q;
		err_latched_d = err_latched_q;
		err_c         = ERR_NONE;
		cp_c          = '0;
		done_c        = 1'b0;
		emit_c        = 1'b0;
		res_c         = '0;

		if (!err_latched_q) begin
			if (pend_q == 2'd0) begin
				if (byte_s1[7] == 1'b0) begin
					cp_c   = {13'd0, byte_s1};
					done_c = 1'b1;
				end else if (byte_s1[7:5] == 3'b110) begin
					pend_d    = 2'd1;
					partial_d = {16'd0, byte_s1[4:0]};
				end else if (byte_s1[7:4] == 4'b1110) begin
					pend_d    = 2'd2;
					partial_d = {17'd0, byte_s1[3:0]};
				end else if (byte_s1[7:3] == 5'b11110) begin
					pend_d    = 2'd3;
					partial_d = {18'd0, byte_s1[2:0]};
				end else begin
					err_c = ERR_BAD_LEAD;
				end
				lead_ed_d    = (byte_s1 == 8'hED);
				first_cont_d = (pend_d != 2'd0);
			end else begin
				if (lead_ed_q && first_cont_q && byte_s1[7:5] == 3'b101) begin
					err_c = ERR_SURROGATE;
				end else if (byte_s1[7:6] != 2'b10) begin
					err_c = ERR_BAD_CONT;
				end else begin
					partial_d    = {partial_q[CpW-7:0], byte_s1[5:0]};
					pend_d       = pend_q - 2'd1;
					first_cont_d = 1'b0;
					if (pend_d == 2'd0) begin
						cp_c   = partial_d;
						done_c = 1'b1;
					end
				end
			end
			if (err_c == ERR_NONE && last_s1 && pend_d != 2'd0) begin
				err_c = ERR_TRUNCATED;
			end
		end

		if (err_c != ERR_NONE) begin
			err_latched_d    = 1'b1;
			pend_d           = 2'd0;
			partial_d        = '0;
			emit_c           = 1'b1;
			res_c.error_code = err_c;
		end else if (done_c) begin
			partial_d          = '0;
			emit_c             = 1'b1;
			res_c.code_point   = cp_c;
			res_c.printable    = is_printable(cp_c);
			res_c.string_valid = last_s1;
		end else if (last_s1) begin
			emit_c             = 1'b1;
			res_c.string_valid = !err_latched_q;
		end

		if (last_s1) begin
			pend_d        = 2'd0;
			partial_d     = '0;
			lead_ed_d     = 1'b0;
			first_cont_d  = 1'b0;
			err_latched_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q        <= 2'd0;
			partial_q     <= '0;
			lead_ed_q     <= 1'b0;
			first_cont_q  <= 1'b0;
			err_latched_q <= 1'b0;
		end else if (fire_s1) begin
			pend_q        <= pend_d;
			partial_q     <= partial_d;
			lead_ed_q     <= lead_ed_d;
			first_cont_q  <= first_cont_d;
			err_latched_q <= err_latched_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= emit_c;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_c) begin
			out_q      <= res_c;
			out_last_q <= last_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_err_zero_cp: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.error_code != ERR_NONE) |-> (out_q.code_point == '0 && !out_q.string_valid))
		else $error("Error transaction carries a code point or a valid string flag.");

	a_valid_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.string_valid) |-> m_tlast)
		else $error("String valid flag set on a transaction that does not end the string.");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && err_latched_q && !last_s1) |=> (err_latched_q && pend_q == 2'd0))
		else $error("Latched error cleared before the last byte of the string.");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && last_s1) |=> (!err_latched_q && pend_q == 2'd0 && partial_q == '0))
		else $error("Decoder state not cleared after the last byte of the string.");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the UTF-8 validating decoder with streaming stimulus and checks.
`timescale 1ns / 1ps

module tb
	import u8vd_pkg::*;
;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
	} text_byte_t;

	typedef struct packed {
		logic    eos;
		result_t res;
	} decoded_t;

	localparam logic [20:0] SPECIAL_CPS [26] = '{
		21'h00, 21'h1F, 21'h20, 21'h7E, 21'h7F, 21'h80, 21'h9F, 21'hA0,
		21'h200D, 21'h200E, 21'h200F, 21'h2027, 21'h2028, 21'h2029, 21'h202A, 21'h202E,
		21'h202F, 21'hD7FF, 21'hD800, 21'hDFFF, 21'hFFF8, 21'hFFF9, 21'hFFFF, 21'h10000,
		21'h10FFFF, 21'h1FFFFF
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;

	text_byte_t  byte_stream[$];
	decoded_t    decoded_q[$];
	logic [7:0]  str_buf[$];

	logic        in_took = 1'b0;
	logic        quiet = 1'b0;
	int          mismatches = 0;
	int          n_results = 0;
	int          gap_left = 0;
	int          stall_left = 0;
	int          hold_left = 0;
	logic        held_once = 1'b0;

	// Decoder state mirrored by the predictor.
	logic [1:0]  cont_left = 2'd0;
	logic [20:0] code_acc = 21'd0;
	logic        seen_ed = 1'b0;
	logic        at_first_cont = 1'b0;
	logic        in_error = 1'b0;

	utf8_validate_decode_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic glyph_visible(input logic [20:0] cp);
		if (cp < 21'h20 || (cp >= 21'h7F && cp < 21'hA0))
			return 1'b0;
		if (cp == 21'h200E || cp == 21'h200F || cp == 21'h2028 || cp == 21'h2029)
			return 1'b0;
		if (cp >= 21'h202A && cp <= 21'h202E)
			return 1'b0;
		return !(cp >= 21'hFFF9 && cp <= 21'hFFFF);
	endfunction

	function automatic logic decode_step(input logic [7:0] b, input logic is_fin,
			output decoded_t d);
		logic [ErrW-1:0] err;
		logic [20:0]     cp;
		logic            done;
		logic            has;
		err = ERR_NONE;
		cp = 21'd0;
		done = 1'b0;
		has = 1'b0;
		d = '0;
		if (in_error) begin
		end else if (cont_left == 2'd0) begin
			if (!b[7]) begin
				cp = {13'd0, b};
				done = 1'b1;
			end else if (b[7:5] == 3'b110) begin
				cont_left = 2'd1;
				code_acc = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				cont_left = 2'd2;
				code_acc = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				cont_left = 2'd3;
				code_acc = {18'd0, b[2:0]};
			end else begin
				err = ERR_BAD_LEAD;
			end
			seen_ed = (b == 8'hED);
			at_first_cont = (cont_left != 2'd0);
		end else begin
			if (seen_ed && at_first_cont && b[7:5] == 3'b101) begin
				err = ERR_SURROGATE;
			end else if (b[7:6] != 2'b10) begin
				err = ERR_BAD_CONT;
			end else begin
				code_acc = {code_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				at_first_cont = 1'b0;
				if (cont_left == 2'd0) begin
					cp = code_acc;
					done = 1'b1;
				end
			end
		end
		if (!in_error && err == ERR_NONE && is_fin && cont_left != 2'd0)
			err = ERR_TRUNCATED;
		if (err != ERR_NONE) begin
			in_error = 1'b1;
			cont_left = 2'd0;
			code_acc = 21'd0;
			d.res.error_code = err;
			d.eos = is_fin;
			has = 1'b1;
		end else if (done) begin
			code_acc = 21'd0;
			d.res.code_point = cp;
			d.res.printable = glyph_visible(cp);
			d.eos = is_fin;
			d.res.string_valid = is_fin;
			has = 1'b1;
		end else if (is_fin) begin
			d.eos = 1'b1;
			d.res.string_valid = !in_error;
			has = 1'b1;
		end
		if (is_fin) begin
			cont_left = 2'd0;
			code_acc = 21'd0;
			seen_ed = 1'b0;
			at_first_cont = 1'b0;
			in_error = 1'b0;
		end
		return has;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic commit_string();
		text_byte_t t;
		for (int i = 0; i < str_buf.size(); i++) begin
			t.data = str_buf[i];
			t.fin = (i == str_buf.size() - 1);
			byte_stream.push_back(t);
		end
		str_buf.delete();
	endtask

	task automatic fill_random(input int unsigned n_bytes);
		int unsigned queued;
		int unsigned n_chars;
		int unsigned kind;
		int unsigned len;
		int unsigned pos;
		logic [20:0] cp;
		queued = 0;
		while (queued < n_bytes) begin
			n_chars = $urandom_range(1, 10);
			for (int c = 0; c < n_chars; c++) begin
				kind = $urandom_range(0, 7);
				case (kind)
					0, 1, 2: begin
						cp = 21'($urandom_range(0, 8'h7F));
						len = 1;
					end
					3: begin
						cp = 21'($urandom_range(0, 16'h7FF));
						len = 2;
					end
					4: begin
						cp = 21'($urandom_range(0, 16'hFFFF));
						len = 3;
					end
					5: begin
						cp = 21'($urandom_range(0, 21'h1FFFFF));
						len = 4;
					end
					default: begin
						cp = SPECIAL_CPS[$urandom_range(0, $size(SPECIAL_CPS) - 1)];
						len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
					end
				endcase
				case (len)
					1: str_buf.push_back(cp[7:0]);
					2: begin
						str_buf.push_back({3'b110, cp[10:6]});
						str_buf.push_back({2'b10, cp[5:0]});
					end
					3: begin
						str_buf.push_back({4'b1110, cp[15:12]});
						str_buf.push_back({2'b10, cp[11:6]});
						str_buf.push_back({2'b10, cp[5:0]});
					end
					default: begin
						str_buf.push_back({5'b11110, cp[20:18]});
						str_buf.push_back({2'b10, cp[17:12]});
						str_buf.push_back({2'b10, cp[11:6]});
						str_buf.push_back({2'b10, cp[5:0]});
					end
				endcase
			end
			// Most strings stay well formed; the rest get a broken byte, a cut tail or noise.
			case ($urandom_range(0, 9))
				0: begin
					pos = $urandom_range(0, str_buf.size() - 1);
					str_buf[pos] = 8'($urandom_range(0, 255));
				end
				1: begin
					pos = $urandom_range(1, str_buf.size());
					while (str_buf.size() > pos)
						void'(str_buf.pop_back());
				end
				2: begin
					str_buf.delete();
					repeat ($urandom_range(1, 8))
						str_buf.push_back(8'($urandom_range(0, 255)));
				end
				default: ;
			endcase
			queued += str_buf.size();
			commit_string();
		end
	endtask

	task automatic wait_drained();
		while (byte_stream.size() != 0 || s_tvalid || decoded_q.size() != 0)
			@(posedge clk);
	endtask

	always @(negedge clk) begin : driver
		text_byte_t t;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_took) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (byte_stream.size() != 0) begin
				t = byte_stream.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= t.data;
				s_tlast <= t.fin;
				if (!quiet && $urandom_range(0, 7) == 0)
					gap_left = $urandom_range(1, 3);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : receiver
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!held_once && n_results >= 300) begin
			held_once = 1'b1;
			hold_left = 63;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		decoded_t d;
		decoded_t e;
		result_t  got;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				if (decode_step(s_tdata, s_tlast, d))
					decoded_q.push_back(d);
			end
			if (m_tvalid && m_tready) begin
				n_results++;
				got = result_t'(m_tdata[25:0]);
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result tdata=%08h tlast=%b",
						m_tdata, m_tlast));
				end else begin
					e = decoded_q.pop_front();
					if (got.code_point !== e.res.code_point || got.printable !== e.res.printable
							|| got.error_code !== e.res.error_code
							|| got.string_valid !== e.res.string_valid
							|| m_tdata[31:26] !== 6'd0 || m_tlast !== e.eos)
						report_mismatch($sformatf(
							"cp %06h/%06h prt %b/%b err %0d/%0d valid %b/%b eos %b/%b pad %02h",
							got.code_point, e.res.code_point, got.printable, e.res.printable,
							got.error_code, e.res.error_code, got.string_valid,
							e.res.string_valid, m_tlast, e.eos, m_tdata[31:26]));
				end
			end
		end
		in_took <= arst_n && s_tvalid && s_tready;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Controls, C1 range and the largest two-byte value.
		str_buf = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
		commit_string();
		// Line separator and the first of the specials.
		str_buf = '{8'hE2, 8'h80, 8'hA8, 8'hEF, 8'hBF, 8'hB9};
		commit_string();
		// Highest four-byte lead with all continuation bits set.
		str_buf = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
		commit_string();
		// Surrogate after an ED lead, then silence until the closing result.
		str_buf = '{8'hED, 8'hA0, 8'h80};
		commit_string();
		// Bad continuation, silent bad lead, closing result.
		str_buf = '{8'hC3, 8'h41, 8'hFF};
		commit_string();
		// Bad lead on the last byte.
		str_buf = '{8'hF8};
		commit_string();
		// Sequence cut short by the last byte.
		str_buf = '{8'hE2, 8'h82};
		commit_string();

		fill_random(900);
		wait_drained();
		fill_random(600);
		wait_drained();
		quiet = 1'b1;
		fill_random(300);
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && decoded_q.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/core/u8vd_pkg.sv
rtl/core/utf8_validate_decode_unit.sv
tb/sv/tb.sv
